### design/rv32i_branch_store_upper_execute_top_assert.svh
// Assertion macros for the execute block. The clock is aclk and the reset is aresetn.
`ifndef RV32I_BRANCH_STORE_UPPER_EXECUTE_TOP_ASSERT_SVH
`define RV32I_BRANCH_STORE_UPPER_EXECUTE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// expr must hold at every clock edge while out of reset
`define RBSU_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("rbsu assertion failed");
// cons must hold in the cycle after ante
`define RBSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rbsu assertion failed");
`else
`define RBSU_ASSERT_ALWAYS(lbl, expr)
`define RBSU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/rbsu_pkg.sv
`timescale 1ns / 1ps
package rbsu_pkg;

    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_SB = 3'd0;
    localparam logic [2:0] F3_SH = 3'd1;
    localparam logic [2:0] F3_SW = 3'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISALIGN = 2'd1,
        ST_RANGE    = 2'd2,
        ST_UNKNOWN  = 2'd3
    } status_t;

    // everything one instruction produces
    typedef struct packed {
        logic [31:0] next_pc;
        logic        branch_taken;
        status_t     status;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic [2:0]  store_bytes;
        logic [31:0] store_addr;
        logic [31:0] store_data;
    } exec_res_t;

    // write request toward the data store
    typedef struct packed {
        logic        we;
        logic [31:0] addr;
        logic [2:0]  nbytes;
        logic [31:0] data;
    } store_req_t;

endpackage

### design/rv32i_branch_store_upper_execute_top.sv
`timescale 1ns / 1ps
`include "rv32i_branch_store_upper_execute_top_assert.svh"
// RV32I execute block for BEQ/BNE/BLT/BGE/BLTU/BGEU, SB/SH/SW, LUI and AUIPC.
// One instruction word per transfer on s_*, one result per instruction on m_*,
// in order. Throughput is one instruction per cycle while m_ready keeps the
// output draining; the register file read shares the instruction transfer edge,
// and execute lands in the output register when stage 1 fires. The
// register file is a 32x32 synchronous RAM read at accept time (two copies, one
// per source operand); a result written by the instruction just ahead is
// forwarded, and a flop per entry marks it as ever written, so unwritten
// entries and x0 read as zero. The PC register sits in the execute stage, so
// the PC-to-next-PC path (adder, branch compare, select) sets the clock. Stores
// go to a byte-laned data RAM of DATA_MEMORY_BYTES bytes that is never read
// back. The PC starts at zero after reset; there is no clearing pass. s_ready
// stays low while aresetn is asserted.
module rv32i_branch_store_upper_execute_top import rbsu_pkg::*; #(
    parameter int DATA_MEMORY_BYTES = 8192
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_instr_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_pc,
    output logic        m_branch_taken,
    output logic [1:0]  m_status,
    output logic        m_reg_write,
    output logic [4:0]  m_reg_index,
    output logic [31:0] m_reg_value,
    output logic [2:0]  m_store_bytes,
    output logic [12:0] m_store_address,
    output logic [31:0] m_store_data
);

    // stage 1: instruction waiting on its register file read data
    logic        s1_valid_reg, s1_valid_next;
    logic [31:0] s1_instr_reg;
    logic [31:0] pc_reg;
    logic [31:0] rf_written_reg;
    // last register write, for the read that happened at the same edge
    logic        fwd_valid_reg;
    logic [4:0]  fwd_idx_reg;
    logic [31:0] fwd_val_reg;
    // output register
    logic        m_valid_reg, m_valid_next;
    exec_res_t   out_reg;

    logic        s_accept;
    logic        exec_fire;
    logic [31:0] rd1_data, rd2_data;
    logic [4:0]  rs1_idx, rs2_idx;
    logic [31:0] rs1_val, rs2_val;
    exec_res_t   res;
    store_req_t  st_req;

    assign exec_fire = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = aresetn && (!s1_valid_reg || exec_fire);
    assign s_accept  = s_valid && s_ready;

    // operand read: two RAM copies share the write port
    rbsu_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .clk   (aclk),
        .we    (exec_fire && res.reg_write),
        .waddr (res.reg_index),
        .wdata (res.reg_value),
        .re    (s_accept),
        .raddr (s_instr_word[19:15]),
        .rdata (rd1_data)
    );

    rbsu_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .clk   (aclk),
        .we    (exec_fire && res.reg_write),
        .waddr (res.reg_index),
        .wdata (res.reg_value),
        .re    (s_accept),
        .raddr (s_instr_word[24:20]),
        .rdata (rd2_data)
    );

    assign rs1_idx = s1_instr_reg[19:15];
    assign rs2_idx = s1_instr_reg[24:20];

    // priority: x0, then same-edge write, then RAM if ever written, else zero
    always_comb begin
        if (rs1_idx == 5'd0) begin
            rs1_val = '0;
        end else if (fwd_valid_reg && fwd_idx_reg == rs1_idx) begin
            rs1_val = fwd_val_reg;
        end else if (rf_written_reg[rs1_idx]) begin
            rs1_val = rd1_data;
        end else begin
            rs1_val = '0;
        end

        if (rs2_idx == 5'd0) begin
            rs2_val = '0;
        end else if (fwd_valid_reg && fwd_idx_reg == rs2_idx) begin
            rs2_val = fwd_val_reg;
        end else if (rf_written_reg[rs2_idx]) begin
            rs2_val = rd2_data;
        end else begin
            rs2_val = '0;
        end
    end

    rbsu_exec #(.DMEM_BYTES(DATA_MEMORY_BYTES)) u_exec (
        .instr   (s1_instr_reg),
        .rs1_val (rs1_val),
        .rs2_val (rs2_val),
        .pc      (pc_reg),
        .res     (res)
    );

    always_comb begin
        st_req.we     = exec_fire && (res.store_bytes != 3'd0);
        st_req.addr   = res.store_addr;
        st_req.nbytes = res.store_bytes;
        st_req.data   = res.store_data;
    end

    rbsu_dstore #(.DMEM_BYTES(DATA_MEMORY_BYTES)) u_dstore (
        .clk (aclk),
        .req (st_req)
    );

    assign s1_valid_next = s_accept || (s1_valid_reg && !exec_fire);
    assign m_valid_next  = exec_fire || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            pc_reg         <= '0;
            rf_written_reg <= '0;
            fwd_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (exec_fire) begin
                pc_reg        <= res.next_pc;
                fwd_valid_reg <= res.reg_write;
                if (res.reg_write) begin
                    rf_written_reg[res.reg_index] <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_instr_reg <= s_instr_word;
        end
        if (exec_fire) begin
            out_reg     <= res;
            fwd_idx_reg <= res.reg_index;
            fwd_val_reg <= res.reg_value;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_next_pc       = out_reg.next_pc;
    assign m_branch_taken  = out_reg.branch_taken;
    assign m_status        = out_reg.status;
    assign m_reg_write     = out_reg.reg_write;
    assign m_reg_index     = out_reg.reg_index;
    assign m_reg_value     = out_reg.reg_value;
    assign m_store_bytes   = out_reg.store_bytes;
    assign m_store_address = out_reg.store_addr[12:0];
    assign m_store_data    = out_reg.store_data;

    // a taken branch always lands word aligned and reports ok
    `RBSU_ASSERT_ALWAYS(a_taken_aligned,
        !(m_valid && m_branch_taken) || (m_next_pc[1:0] == 2'd0 && m_status == ST_OK))
    // a performed store never carries a fault status
    `RBSU_ASSERT_ALWAYS(a_store_ok, !(m_valid && m_store_bytes != 3'd0) || m_status == ST_OK)
    // x0 is never reported as written
    `RBSU_ASSERT_ALWAYS(a_no_x0_write, !(m_valid && m_reg_write) || m_reg_index != 5'd0)
    // executing an instruction always presents a result next cycle
    `RBSU_ASSERT_NEXT(a_exec_to_out, exec_fire, m_valid)

endmodule

### design/rbsu_ram.sv
`timescale 1ns / 1ps
module rbsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/rbsu_exec.sv
`timescale 1ns / 1ps
module rbsu_exec import rbsu_pkg::*; #(
    parameter int DMEM_BYTES = 8192
) (
    input  logic [31:0] instr,
    input  logic [31:0] rs1_val,
    input  logic [31:0] rs2_val,
    input  logic [31:0] pc,
    output exec_res_t   res
);

    logic [6:0]  opcode;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] imm_b;
    logic [31:0] imm_s;
    logic [31:0] pc_plus4;
    logic [31:0] target;
    logic [31:0] st_addr;
    logic [32:0] st_end;
    logic [31:0] upper;
    logic [2:0]  nbytes;
    logic        cond;
    logic        br_known;

    assign opcode   = instr[6:0];
    assign f3       = instr[14:12];
    assign rd       = instr[11:7];
    assign imm_b    = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    assign imm_s    = {{20{instr[31]}}, instr[31:25], instr[11:7]};
    assign pc_plus4 = pc + 32'd4;
    assign target   = pc + imm_b;
    assign st_addr  = rs1_val + imm_s;
    assign st_end   = {1'b0, st_addr} + {30'd0, nbytes};
    assign upper    = {instr[31:12], 12'd0};

    always_comb begin
        br_known = 1'b1;
        case (f3)
            F3_BEQ:  cond = (rs1_val == rs2_val);
            F3_BNE:  cond = (rs1_val != rs2_val);
            F3_BLT:  cond = ($signed(rs1_val) < $signed(rs2_val));
            F3_BGE:  cond = ($signed(rs1_val) >= $signed(rs2_val));
            F3_BLTU: cond = (rs1_val < rs2_val);
            F3_BGEU: cond = (rs1_val >= rs2_val);
            default: begin
                cond     = 1'b0;
                br_known = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (f3)
            F3_SB:   nbytes = 3'd1;
            F3_SH:   nbytes = 3'd2;
            F3_SW:   nbytes = 3'd4;
            default: nbytes = 3'd0;
        endcase
    end

    always_comb begin
        res = '0;
        res.next_pc = pc_plus4;
        res.status  = ST_OK;
        case (opcode)
            OP_BRANCH: begin
                if (!br_known) begin
                    res.status = ST_UNKNOWN;
                end else if (cond) begin
                    if (target[1:0] != 2'd0) begin
                        res.status = ST_MISALIGN;
                    end else begin
                        res.next_pc      = target;
                        res.branch_taken = 1'b1;
                    end
                end
            end
            OP_STORE: begin
                if (nbytes == 3'd0) begin
                    res.status = ST_UNKNOWN;
                end else if (st_end > 33'(DMEM_BYTES)) begin
                    res.status = ST_RANGE;
                end else begin
                    res.store_bytes = nbytes;
                    res.store_addr  = st_addr;
                    res.store_data  = rs2_val;
                end
            end
            OP_LUI, OP_AUIPC: begin
                if (rd != 5'd0) begin
                    res.reg_write = 1'b1;
                    res.reg_index = rd;
                    res.reg_value = (opcode == OP_AUIPC) ? upper + pc : upper;
                end
            end
            default: res.status = ST_UNKNOWN;
        endcase
    end

endmodule

### design/rbsu_dstore.sv
`timescale 1ns / 1ps
module rbsu_dstore import rbsu_pkg::*; #(
    parameter int DMEM_BYTES = 8192
) (
    input  logic       clk,
    input  store_req_t req
);

    localparam int AW         = $clog2(DMEM_BYTES);
    localparam int LANE_DEPTH = (DMEM_BYTES + 3) / 4;

    // four byte lanes; byte k of the store lands in lane (addr + k) mod 4
    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [1:0]    off;
        logic [AW-1:0] baddr;
        logic          lane_we;
        logic [7:0]    lane_data;

        assign off       = 2'(l) - req.addr[1:0];
        assign baddr     = req.addr[AW-1:0] + AW'(off);
        assign lane_we   = req.we && ({1'b0, off} < req.nbytes);
        assign lane_data = 8'(req.data >> {off, 3'b000});

        rbsu_ram #(
            .WIDTH (8),
            .DEPTH (LANE_DEPTH)
        ) u_lane (
            .clk   (clk),
            .we    (lane_we),
            .waddr (baddr[AW-1:2]),
            .wdata (lane_data),
            .re    (1'b0),
            .raddr ('0),
            .rdata ()
        );
    end

endmodule
